### rtl/plvc_pkg.sv
// Shared types, breakpoint tables and datapath constants of the voltage correction block.
package plvc_pkg;

  // Breakpoint table geometry.
  localparam int NUM_POINTS = 8;
  localparam int LAST       = NUM_POINTS - 1;
  localparam int IDX_W      = $clog2(NUM_POINTS);
  localparam int V_W        = 16;
  localparam int GAIN_W     = 10;

  // Datapath widths: multiplicand, reciprocal, numerator factor, divisor, quotient.
  localparam int A_W   = 26;
  localparam int K_W   = 31;
  localparam int B_W   = 16;
  localparam int D_W   = 26;
  localparam int Q_W   = 16;
  localparam int N_W   = A_W + B_W;
  localparam int M_W   = A_W + K_W;
  localparam int FRAC  = 26;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result region codes.
  localparam logic [1:0] REGION_EXACT  = 2'd0;
  localparam logic [1:0] REGION_INTERP = 2'd1;
  localparam logic [1:0] REGION_EXTRAP = 2'd2;

  // Breakpoints, input mV to output mV.
  localparam logic [V_W-1:0] BP_IN [NUM_POINTS] = '{
    16'd0, 16'd12, 16'd291, 16'd3200, 16'd5313, 16'd14342, 16'd25801, 16'd32809
  };
  localparam logic [V_W-1:0] BP_OUT [NUM_POINTS] = '{
    16'd0, 16'd300, 16'd580, 16'd3200, 16'd5212, 16'd13790, 16'd24460, 16'd30950
  };

  // Per segment: width, rise, and floor(rise * 2^FRAC / width).
  // The entry after the last segment is never selected for interpolation.
  localparam logic [D_W-1:0] SEG_DX [NUM_POINTS] = '{
    26'd12, 26'd279, 26'd2909, 26'd2113, 26'd9029, 26'd11459, 26'd7008, 26'd1
  };
  localparam logic [B_W-1:0] SEG_DY [NUM_POINTS] = '{
    16'd300, 16'd280, 16'd2620, 16'd2012, 16'd8578, 16'd10670, 16'd6490, 16'd0
  };
  localparam logic [K_W-1:0] SEG_K [NUM_POINTS] = '{
    31'd1677721600, 31'd67349397, 31'd60441809, 31'd63901104,
    31'd63756765, 31'd62488138, 31'd62148477, 31'd0
  };

  // Extrapolation: divisor 1000 * last input and floor(last_out * 2^FRAC / divisor).
  localparam logic [D_W-1:0] EXT_DIV = 26'd32809000;
  localparam logic [K_W-1:0] EXT_K   = 31'd63306;

  // How the back part must treat a word.
  typedef enum logic [1:0] {
    KIND_EXACT,
    KIND_INTERP,
    KIND_EXTRAP,
    KIND_PASS
  } kind_t;

  // Classified word passed from the front through the queue.
  typedef struct packed {
    logic [V_W-1:0]   v;
    kind_t            kind;
    logic [IDX_W-1:0] idx;
  } item_t;

  // Queue status seen by the front.
  typedef struct packed {
    logic full;
  } queue_status_t;

endpackage

### rtl/plvc_front.sv
// Front part: accepts input words and classifies them against the breakpoint table.
module plvc_front import plvc_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [V_W-1:0] voltage_mv,
  input  queue_status_t  qstat,
  output logic           push,
  output item_t          push_item
);

  logic             valid;
  item_t            item;
  item_t            item_next;
  logic             eq_found;
  logic [IDX_W-1:0] eq_idx;
  logic             lt_found;
  logic [IDX_W-1:0] lt_idx;
  logic             load;

  // The held word moves on whenever the queue has room.
  assign push     = valid && !qstat.full;
  assign load     = !valid || !qstat.full;
  assign in_stall = !load;

  // Lowest exact match and the first breakpoint above the input.
  always_comb begin
    eq_found = 1'b0;
    eq_idx   = '0;
    lt_found = 1'b0;
    lt_idx   = '0;
    for (int i = NUM_POINTS - 1; i >= 0; i--) begin
      if (voltage_mv == BP_IN[i]) begin
        eq_found = 1'b1;
        eq_idx   = IDX_W'(i);
      end
    end
    for (int i = NUM_POINTS - 1; i >= 1; i--) begin
      if (voltage_mv < BP_IN[i]) begin
        lt_found = 1'b1;
        lt_idx   = IDX_W'(i - 1);
      end
    end
  end

  // Classification in the same priority as the correction rules.
  always_comb begin
    item_next.v    = voltage_mv;
    item_next.kind = KIND_PASS;
    item_next.idx  = '0;
    if (eq_found) begin
      item_next.kind = KIND_EXACT;
      item_next.idx  = eq_idx;
    end else if (lt_found) begin
      item_next.kind = KIND_INTERP;
      item_next.idx  = lt_idx;
    end else if (voltage_mv > BP_IN[LAST]) begin
      item_next.kind = KIND_EXTRAP;
    end
  end

  // Holding register for the classified word.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item <= item_next;
    end
  end

  assign push_item = item;

endmodule

### rtl/plvc_queue.sv
// Short queue of classified words between the front and the back part.
module plvc_queue import plvc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  item_t         push_item,
  output queue_status_t qstat,
  input  logic          pop,
  output logic          pop_valid,
  output item_t         pop_item
);

  item_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign qstat.full = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full && !pop))
    else $error("word written into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> pop_valid)
    else $error("word taken from an empty queue");

endmodule

### rtl/plvc_back.sv
// Back part: pipelined interpolation and extrapolation with reciprocal division.
module plvc_back import plvc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [GAIN_W-1:0] gain,
  input  logic              pop_valid,
  input  item_t             pop_item,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [V_W-1:0]    corrected_mv,
  output logic [1:0]        region
);

  // Stage enables, from the output backwards.
  logic en1;
  logic en2;
  logic en3;
  logic en_out;

  // Stage 1: operands.
  logic           v1;
  logic [A_W-1:0] s1_a;
  logic [B_W-1:0] s1_b;
  logic [K_W-1:0] s1_k;
  logic [D_W-1:0] s1_d;
  logic [V_W-1:0] s1_y0;
  logic [1:0]     s1_region;
  logic [A_W-1:0] s1_a_next;
  logic [B_W-1:0] s1_b_next;
  logic [K_W-1:0] s1_k_next;
  logic [D_W-1:0] s1_d_next;
  logic [V_W-1:0] s1_y0_next;
  logic [1:0]     s1_region_next;
  logic [V_W-1:0] diff_lo;
  logic [V_W-1:0] diff_hi;

  // Stage 2: quotient estimate and exact numerator.
  logic           v2;
  logic [Q_W-1:0] s2_q;
  logic [N_W-1:0] s2_n;
  logic [D_W-1:0] s2_d;
  logic [V_W-1:0] s2_y0;
  logic [1:0]     s2_region;
  logic [M_W-1:0] est;

  // Stage 3: estimate times divisor.
  logic           v3;
  logic [Q_W-1:0] s3_q;
  logic [N_W-1:0] s3_n;
  logic [N_W-1:0] s3_qd;
  logic [D_W-1:0] s3_d;
  logic [V_W-1:0] s3_y0;
  logic [1:0]     s3_region;

  // Final correction and saturation.
  logic [N_W-1:0] rem;
  logic           bump;
  logic [V_W:0]   sum;

  assign en_out = !out_valid || !out_stall;
  assign en3    = !v3 || en_out;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;
  assign pop    = pop_valid && en1;

  // Operand selection; an exact match or pass-through has a zero quotient.
  always_comb begin
    diff_lo        = pop_item.v - BP_IN[pop_item.idx];
    diff_hi        = pop_item.v - BP_IN[LAST];
    s1_a_next      = '0;
    s1_b_next      = '0;
    s1_k_next      = '0;
    s1_d_next      = D_W'(1);
    s1_y0_next     = pop_item.v;
    s1_region_next = REGION_INTERP;
    case (pop_item.kind)
      KIND_EXACT: begin
        s1_y0_next     = BP_OUT[pop_item.idx];
        s1_region_next = REGION_EXACT;
      end
      KIND_INTERP: begin
        s1_a_next  = A_W'(diff_lo);
        s1_b_next  = SEG_DY[pop_item.idx];
        s1_k_next  = SEG_K[pop_item.idx];
        s1_d_next  = SEG_DX[pop_item.idx];
        s1_y0_next = BP_OUT[pop_item.idx];
      end
      KIND_EXTRAP: begin
        s1_a_next      = A_W'(diff_hi) * A_W'(gain);
        s1_b_next      = BP_OUT[LAST];
        s1_k_next      = EXT_K;
        s1_d_next      = EXT_DIV;
        s1_y0_next     = BP_OUT[LAST];
        s1_region_next = REGION_EXTRAP;
      end
      default: begin
        s1_y0_next = pop_item.v;
      end
    endcase
  end

  assign est = M_W'(s1_a) * M_W'(s1_k);

  // Valid bits of the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= pop_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en_out) begin
        out_valid <= v3;
      end
    end
  end

  // Payload registers of the pipeline.
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_a      <= s1_a_next;
      s1_b      <= s1_b_next;
      s1_k      <= s1_k_next;
      s1_d      <= s1_d_next;
      s1_y0     <= s1_y0_next;
      s1_region <= s1_region_next;
    end
    if (en2) begin
      s2_q      <= est[FRAC +: Q_W];
      s2_n      <= N_W'(s1_a) * N_W'(s1_b);
      s2_d      <= s1_d;
      s2_y0     <= s1_y0;
      s2_region <= s1_region;
    end
    if (en3) begin
      s3_q      <= s2_q;
      s3_n      <= s2_n;
      s3_qd     <= N_W'(s2_q) * N_W'(s2_d);
      s3_d      <= s2_d;
      s3_y0     <= s2_y0;
      s3_region <= s2_region;
    end
    if (en_out) begin
      corrected_mv <= sum[V_W] ? {V_W{1'b1}} : sum[V_W-1:0];
      region       <= s3_region;
    end
  end

  // The estimate is low by at most one; one compare settles it.
  assign rem  = s3_n - s3_qd;
  assign bump = (rem >= N_W'(s3_d));
  assign sum  = (V_W+1)'(s3_y0) + (V_W+1)'(s3_q) + (V_W+1)'(bump);

  a_rem_nonneg: assert property (@(posedge clk) disable iff (rst)
    v3 |-> s3_n >= s3_qd)
    else $error("quotient estimate above the true quotient");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v3 |-> rem < (N_W'(s3_d) << 1))
    else $error("quotient estimate more than one below the true quotient");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !en3 |=> v3 && $stable(s3_n) && $stable(s3_q))
    else $error("blocked stage lost or changed its word");

endmodule

### rtl/piecewise_linear_voltage_correction.sv
// Top level of the piecewise-linear voltage correction block.
//
//   Channel  Handshake            Payload
//   input    in_valid / in_stall  voltage_mv[15:0]
//   output   out_valid / out_stall corrected_mv[15:0], region[1:0]
//   config   cfg_wr_en            cfg_wr_data[9:0] (extrapolation gain, per mille)
//
// One word is accepted every cycle while in_stall is low; the multiply-by-reciprocal pipeline sustains that.
// From acceptance to result a word passes the front register, the queue,
// three arithmetic stages and the output register.
// Reset clears all valid state and sets the gain to 100; no clearing pass is needed.
// A stall on the output fills the back pipeline and then the four-word queue before
// in_stall rises; the front keeps taking words while the queue has room.
module piecewise_linear_voltage_correction import plvc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [V_W-1:0]    voltage_mv,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [V_W-1:0]    corrected_mv,
  output logic [1:0]        region,
  input  logic              cfg_wr_en,
  input  logic [GAIN_W-1:0] cfg_wr_data
);

  logic [GAIN_W-1:0] gain;
  queue_status_t     qstat;
  logic              push;
  item_t             push_item;
  logic              pop;
  logic              pop_valid;
  item_t             pop_item;

  // Extrapolation gain register.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_W'(100);
    end else if (cfg_wr_en) begin
      gain <= cfg_wr_data;
    end
  end

  plvc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .voltage_mv (voltage_mv),
    .qstat      (qstat),
    .push       (push),
    .push_item  (push_item)
  );

  plvc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .qstat     (qstat),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  plvc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .gain         (gain),
    .pop_valid    (pop_valid),
    .pop_item     (pop_item),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .corrected_mv (corrected_mv),
    .region       (region)
  );

endmodule
